>>> hdl/rnn_pkg.sv
// Shared types and constants for the recurrent network step unit.
package rnn_pkg;

  // Field widths of one input item and one result item
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 4;
  localparam int NODE_W  = 4;
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 16;
  localparam int DESC_W  = KIND_W + NODE_W;

  typedef logic        [MODE_W-1:0] mode_t;
  typedef logic        [IDX_W-1:0]  idx_t;
  typedef logic        [NODE_W-1:0] node_t;
  typedef logic        [KIND_W-1:0] kind_t;
  typedef logic signed [VAL_W-1:0]  q12_t;

  // Operation codes
  localparam mode_t MODE_LOAD_W     = 3'd0;
  localparam mode_t MODE_LOAD_D     = 3'd1;
  localparam mode_t MODE_SET_SENSOR = 3'd2;
  localparam mode_t MODE_CLR_SENSOR = 3'd3;
  localparam mode_t MODE_SET_BIAS   = 3'd4;
  localparam mode_t MODE_UPDATE     = 3'd5;
  localparam mode_t MODE_READ_MOTOR = 3'd6;
  localparam mode_t MODE_NONE       = 3'd7;

  // Neuron kinds
  localparam kind_t KIND_NORMAL = 2'd0;
  localparam kind_t KIND_SENSOR = 2'd1;
  localparam kind_t KIND_MOTOR  = 2'd2;
  localparam kind_t KIND_BIAS   = 2'd3;

  localparam q12_t        Q12_ONE  = 16'sd4096;
  localparam logic [31:0] Q31_ONE  = 32'h8000_0000;
  localparam logic [31:0] EXP_BASE = 32'd2146435328;  // e^(-1/2048) in Q.31

  // Status of the tanh unit
  typedef struct packed {
    logic busy;
    logic done;
  } tanh_stat_t;

endpackage

>>> hdl/rnn_ram.sv
// Generic one-write, one-read synchronous RAM with registered read data.
module rnn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rnn_tanh.sv
// Iterative tanh in Q3.12: square-and-multiply exponent, then bit-serial divide.
module rnn_tanh (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rnn_pkg::q12_t       x,
  output rnn_pkg::tanh_stat_t stat,
  output rnn_pkg::q12_t       y
);
  import rnn_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_EXP  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  logic [1:0]  state_r;
  logic [3:0]  k_r;
  logic [15:0] n_r;
  logic        neg_r;
  logic [31:0] e_r;
  logic [31:0] b_r;
  logic [46:0] rem_r;
  logic [46:0] dsh_r;
  logic [12:0] q_r;

  logic [15:0] x_abs;
  logic [31:0] eb;
  logic [31:0] bb;
  logic [31:0] num;
  logic [32:0] den;
  logic        ge;

  // Q.31 product rounded to nearest
  function automatic logic [31:0] q31_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'h4000_0000;
    return p[62:31];
  endfunction

  assign x_abs = x[15] ? 16'(-x) : 16'(x);
  assign eb    = q31_mul(e_r, b_r);
  assign bb    = q31_mul(b_r, b_r);
  assign num   = Q31_ONE - e_r;
  assign den   = 33'(Q31_ONE) + 33'(e_r);
  assign ge    = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      unique case (state_r)
        T_IDLE: begin
          if (start) begin
            n_r     <= x_abs;
            neg_r   <= x[15];
            e_r     <= Q31_ONE;
            b_r     <= EXP_BASE;
            k_r     <= '0;
            state_r <= T_EXP;
          end
        end
        // one exponent bit per cycle, LSB first
        T_EXP: begin
          if (n_r[0]) begin
            e_r <= eb;
          end
          b_r <= bb;
          n_r <= n_r >> 1;
          k_r <= k_r + 4'd1;
          if (k_r == 4'd15) begin
            state_r <= T_DIV;
          end
        end
        // quotient bits 12 down to 0 of (num*8192 + den) / (2*den)
        T_DIV: begin
          if (k_r == 4'd0) begin
            rem_r <= 47'({num, 13'b0}) + 47'(den);
            dsh_r <= 47'({den, 13'b0});
            q_r   <= '0;
            k_r   <= 4'd1;
          end else begin
            if (ge) begin
              rem_r <= rem_r - dsh_r;
            end
            q_r   <= {q_r[11:0], ge};
            dsh_r <= dsh_r >> 1;
            k_r   <= k_r + 4'd1;
            if (k_r == 4'd13) begin
              state_r <= T_OUT;
            end
          end
        end
        T_OUT: begin
          state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign y         = neg_r ? 16'(-{3'b0, q_r}) : {3'b0, q_r};
  assign stat.busy = state_r != T_IDLE;
  assign stat.done = state_r == T_OUT;

endmodule

>>> hdl/recurrent_neural_network_step_unit.sv
// Recurrent tanh network step unit: weights, activations and descriptors in RAMs.
// Update results are paced by the iterative tanh unit, whose work on each row
// overlaps the next row's multiply-accumulate pass.
// One item at a time; a finished result may wait while the next item is taken.
// After reset a clearing pass zeroes the weight, activation and descriptor RAMs.
module recurrent_neural_network_step_unit #(
  parameter int NEURONS = 16,
  parameter int NODES   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rnn_pkg::mode_t      in_mode,
  input  rnn_pkg::idx_t       in_row_index,
  input  rnn_pkg::idx_t       in_col_index,
  input  rnn_pkg::node_t      in_node,
  input  rnn_pkg::kind_t      in_neuron_kind,
  input  rnn_pkg::q12_t       in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output rnn_pkg::q12_t       out_motor_value,
  output logic                out_motor_found
);
  import rnn_pkg::*;

  localparam int IW    = $clog2(NEURONS);
  localparam int CW    = IW + 1;
  localparam int WA    = $clog2(NEURONS * NEURONS);
  localparam int ACC_W = 32 + IW + 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MAC    = 3'd3;
  localparam logic [2:0] S_TWAIT  = 3'd4;
  localparam logic [2:0] S_TDRAIN = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]              state_r;
  logic [WA:0]             clr_r;
  logic [CW-1:0]           cnt_r;
  logic [IW-1:0]           i_r;
  logic [IW-1:0]           idx_d_r;
  logic [IW-1:0]           tanh_row_r;
  logic [WA-1:0]           waddr_r;
  logic                    rd_v_r;
  logic                    prod_v_r;
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  mode_t                   mode_r;
  node_t                   node_r;
  q12_t                    val_r;
  logic                    hit_r;
  q12_t                    motor_r;
  logic                    out_valid_r;
  q12_t                    out_value_r;
  logic                    out_found_r;

  // RAM ports
  logic              w_we, a_we, d_we, n_we;
  logic [WA-1:0]     w_waddr;
  logic [IW-1:0]     a_waddr, d_waddr, n_waddr;
  q12_t              w_wdata, a_wdata, n_wdata;
  logic [DESC_W-1:0] d_wdata;
  logic [15:0]       w_rdata, a_rdata, n_rdata;
  logic [DESC_W-1:0] d_rdata;

  logic       accept;
  logic       issue;
  logic       first_hit;
  logic       tanh_start;
  tanh_stat_t t_stat;
  q12_t       t_y;
  q12_t       t_x;
  kind_t      d_kind;
  node_t      d_node;
  logic signed [ACC_W-1:0] sum_rnd;

  assign accept = in_valid && in_ready;
  assign issue  = (state_r == S_SCAN || state_r == S_MAC || state_r == S_COMMIT)
                  && cnt_r != CW'(NEURONS);
  assign d_kind = d_rdata[DESC_W-1:NODE_W];
  assign d_node = d_rdata[NODE_W-1:0];

  // First matching sensor or motor descriptor in a scan
  assign first_hit = rd_v_r && !hit_r && d_node == node_r &&
                     ((mode_r == MODE_SET_SENSOR && d_kind == KIND_SENSOR) ||
                      (mode_r == MODE_READ_MOTOR && d_kind == KIND_MOTOR));

  // Round the sum of Q6.24 products to Q3.12, halves up, then saturate
  assign sum_rnd = (acc_r + ACC_W'(2048)) >>> 12;
  always_comb begin
    if (sum_rnd > ACC_W'(32'sd32767)) begin
      t_x = 16'sh7fff;
    end else if (sum_rnd < ACC_W'(-32'sd32768)) begin
      t_x = 16'sh8000;
    end else begin
      t_x = 16'(sum_rnd);
    end
  end

  assign tanh_start = state_r == S_TWAIT && !t_stat.busy;

  // RAM control
  always_comb begin
    w_we    = 1'b0;
    w_waddr = waddr_r;
    w_wdata = in_value;
    a_we    = 1'b0;
    a_waddr = idx_d_r;
    a_wdata = '0;
    d_we    = 1'b0;
    d_waddr = IW'(in_row_index);
    d_wdata = {in_neuron_kind, in_node};
    n_we    = t_stat.done;
    n_waddr = tanh_row_r;
    n_wdata = t_y;
    unique case (state_r)
      S_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_r[WA-1:0];
        w_wdata = '0;
        a_waddr = clr_r[IW-1:0];
        d_waddr = clr_r[IW-1:0];
        d_wdata = '0;
        if (clr_r < (WA+1)'(NEURONS)) begin
          a_we = 1'b1;
          d_we = 1'b1;
        end
      end
      S_IDLE: begin
        if (accept && 32'(in_row_index) < NEURONS) begin
          if (in_mode == MODE_LOAD_W && 32'(in_col_index) < NEURONS) begin
            w_we    = 1'b1;
            w_waddr = WA'(32'(in_row_index) * NEURONS + 32'(in_col_index));
          end
          if (in_mode == MODE_LOAD_D) begin
            d_we = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (rd_v_r) begin
          unique case (mode_r)
            MODE_SET_SENSOR: begin
              a_we    = first_hit;
              a_wdata = val_r;
            end
            MODE_CLR_SENSOR: begin
              a_we    = d_kind == KIND_SENSOR;
              a_wdata = '0;
            end
            MODE_SET_BIAS: begin
              a_we    = d_kind == KIND_BIAS;
              a_wdata = Q12_ONE;
            end
            default: a_we = 1'b0;
          endcase
        end
      end
      S_COMMIT: begin
        a_we    = rd_v_r;
        a_wdata = n_rdata;
      end
      default: a_we = 1'b0;
    endcase
  end

  rnn_ram #(.WIDTH(VAL_W), .DEPTH(NEURONS * NEURONS)) u_weights (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(waddr_r), .rdata(w_rdata)
  );

  rnn_ram #(.WIDTH(VAL_W), .DEPTH(NEURONS)) u_act (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(cnt_r[IW-1:0]), .rdata(a_rdata)
  );

  rnn_ram #(.WIDTH(VAL_W), .DEPTH(NEURONS)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(cnt_r[IW-1:0]), .rdata(n_rdata)
  );

  rnn_ram #(.WIDTH(DESC_W), .DEPTH(NEURONS)) u_desc (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(cnt_r[IW-1:0]), .rdata(d_rdata)
  );

  rnn_tanh u_tanh (
    .clk(clk), .rst_n(rst_n), .start(tanh_start), .x(t_x), .stat(t_stat), .y(t_y)
  );

  // Read pipeline and multiply stage
  always_ff @(posedge clk) begin
    idx_d_r <= cnt_r[IW-1:0];
    prod_r  <= 32'(signed'(w_rdata)) * 32'(signed'(a_rdata));
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r   <= issue;
      prod_v_r <= state_r == S_MAC && rd_v_r;
      if (out_valid_r && out_ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (WA+1)'(NEURONS * NEURONS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            mode_r  <= in_mode;
            node_r  <= in_node;
            val_r   <= in_value;
            cnt_r   <= '0;
            hit_r   <= 1'b0;
            motor_r <= '0;
            i_r     <= '0;
            acc_r   <= '0;
            waddr_r <= '0;
            unique case (in_mode) inside
              MODE_SET_SENSOR, MODE_READ_MOTOR: begin
                state_r <= (32'(in_node) < NODES) ? S_SCAN : S_FINISH;
              end
              MODE_CLR_SENSOR, MODE_SET_BIAS: state_r <= S_SCAN;
              MODE_UPDATE:                    state_r <= S_MAC;
              default:                        state_r <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (first_hit) begin
            hit_r   <= 1'b1;
            motor_r <= a_rdata;
          end
          if (!issue && !rd_v_r) begin
            state_r <= S_FINISH;
          end
        end
        // one weight-activation product per cycle for row i_r
        S_MAC: begin
          if (issue) begin
            cnt_r   <= cnt_r + 1'b1;
            waddr_r <= waddr_r + 1'b1;
          end
          if (prod_v_r) begin
            acc_r <= acc_r + ACC_W'(prod_r);
          end
          if (!issue && !rd_v_r && !prod_v_r) begin
            state_r <= S_TWAIT;
          end
        end
        S_TWAIT: begin
          if (!t_stat.busy) begin
            tanh_row_r <= i_r;
            if (i_r == IW'(NEURONS - 1)) begin
              state_r <= S_TDRAIN;
            end else begin
              i_r     <= i_r + 1'b1;
              cnt_r   <= '0;
              acc_r   <= '0;
              state_r <= S_MAC;
            end
          end
        end
        S_TDRAIN: begin
          if (!t_stat.busy) begin
            cnt_r   <= '0;
            state_r <= S_COMMIT;
          end
        end
        // copy new values into the activation RAM
        S_COMMIT: begin
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (!issue && !rd_v_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= (mode_r == MODE_READ_MOTOR) ? motor_r : '0;
            out_found_r <= mode_r == MODE_READ_MOTOR && hit_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = state_r == S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_motor_value = out_value_r;
  assign out_motor_found = out_found_r;

endmodule
